/* hw/rtl/vh3_pkg.sv */
// Shared constants, types and register map of the 3D velocity histogram.
package vh3_pkg;

  localparam int unsigned BINS_PER_AXIS = 16;
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam int unsigned NUM_BINS      = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int unsigned AXIS_W        = $clog2(BINS_PER_AXIS);
  localparam int unsigned ADDR_W        = $clog2(NUM_BINS);
  localparam int unsigned NUM_AXES      = 3;

  // Register map: one 32-bit register every 4 bytes.
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_SCALE_X  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Z  = REG_IDX_W'(5);

  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_CHK   = 6'b001000,
    S_READ  = 6'b010000,
    S_WB    = 6'b100000
  } state_e;

endpackage

/* hw/rtl/velocity_histogram_3d.sv */
// Top level of the 3D velocity histogram: register port, sequencer and bin memory.
//
// Requests are taken when start is high and busy is low; each request yields one
// result, shown for one cycle with done_o, which the receiver must take then.
// Add and lookup run the three axes one after another through a single 32x32
// multiplier, then read the bin in the memory and, for an add, write it back.
// An unused operation code answers in the next cycle and a new request may
// follow at once. Clear answers in the next cycle and then sweeps all 4096
// bins, one a cycle, with busy high; the same sweep runs after reset.
module velocity_histogram_3d (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic signed [31:0]           vel_x_i,
  input  logic signed [31:0]           vel_y_i,
  input  logic signed [31:0]           vel_z_i,
  // result
  output logic                         done_o,
  output logic [31:0]                  bin_value_o,
  output logic                         in_range_o,
  output logic [31:0]                  total_samples_o,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vh3_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import vh3_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [31:0] origin_q [NUM_AXES];
  logic [31:0] scale_q  [NUM_AXES];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        origin_q[i] <= '0;
        scale_q[i]  <= SCALE_RESET;
      end
    end else if (reg_we) begin
      unique case (reg_idx)
        REG_ORIGIN_X: origin_q[0] <= pwdata;
        REG_ORIGIN_Y: origin_q[1] <= pwdata;
        REG_ORIGIN_Z: origin_q[2] <= pwdata;
        REG_SCALE_X:  scale_q[0]  <= pwdata;
        REG_SCALE_Y:  scale_q[1]  <= pwdata;
        REG_SCALE_Z:  scale_q[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = origin_q[0];
      REG_ORIGIN_Y: prdata = origin_q[1];
      REG_ORIGIN_Z: prdata = origin_q[2];
      REG_SCALE_X:  prdata = scale_q[0];
      REG_SCALE_Y:  prdata = scale_q[1];
      REG_SCALE_Z:  prdata = scale_q[2];
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  state_e                    state_q, state_d;
  logic   [1:0]              op_q, op_d;
  logic   [ADDR_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic   [1:0]              axis_q, axis_d;
  logic   [31:0]             mag_q [NUM_AXES];
  logic                      neg_q [NUM_AXES];
  logic   [63:0]             prod_q, prod_d;
  logic   [AXIS_W-1:0]       idx_q [NUM_AXES];
  logic                      ok_q, ok_d;
  logic   [31:0]             total_q, total_d;
  logic                      done_q, done_d;
  logic   [31:0]             bin_q, bin_d;
  logic                      inr_q, inr_d;

  logic                      accept;
  logic   [31:0]             vel_in [NUM_AXES];
  logic   [32:0]             diff   [NUM_AXES];
  logic   [31:0]             quot;
  logic                      axis_ok;
  logic                      ok_all;
  logic   [ADDR_W-1:0]       bin_addr;
  logic                      ram_we, ram_re;
  logic   [ADDR_W-1:0]       ram_addr;
  logic   [COUNT_WIDTH-1:0]  ram_wdata, ram_rdata;
  logic   [COUNT_WIDTH-1:0]  cnt_new;
  logic   [63:0]             cnt_wide;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign vel_in[0] = vel_x_i;
  assign vel_in[1] = vel_y_i;
  assign vel_in[2] = vel_z_i;

  // Differences span 33 bits; their magnitude always fits in 32.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] = {vel_in[i][31], vel_in[i]} - {origin_q[i][31], origin_q[i]};
    end
  end

  assign quot    = prod_q[63:32];
  assign axis_ok = neg_q[axis_q] ? (quot == '0) : (quot < 32'(BINS_PER_AXIS));
  assign ok_all  = ok_q && axis_ok;

  assign bin_addr = (ADDR_W'(idx_q[0]) * ADDR_W'(BINS_PER_AXIS) + ADDR_W'(idx_q[1]))
                    * ADDR_W'(BINS_PER_AXIS) + ADDR_W'(idx_q[2]);

  assign cnt_new = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    clr_cnt_d = clr_cnt_q;
    axis_d    = axis_q;
    prod_d    = prod_q;
    ok_d      = ok_q;
    total_d   = total_q;
    done_d    = 1'b0;
    bin_d     = bin_q;
    inr_d     = inr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = bin_addr;
    ram_wdata = '0;
    cnt_wide  = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(NUM_BINS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d   = operation_i;
          axis_d = '0;
          ok_d   = 1'b1;
          priority if (operation_i == OP_CLEAR) begin
            total_d   = '0;
            clr_cnt_d = '0;
            done_d    = 1'b1;
            bin_d     = '0;
            inr_d     = 1'b0;
            state_d   = S_CLEAR;
          end else if (operation_i == OP_ADD || operation_i == OP_LOOKUP) begin
            if (operation_i == OP_ADD && total_q != '1) begin
              total_d = total_q + 32'd1;
            end
            state_d = S_MUL;
          end else begin
            // unused code: answer at once with a zero result, leave bins and total unchanged
            done_d = 1'b1;
            bin_d  = '0;
            inr_d  = 1'b0;
          end
        end
      end
      S_MUL: begin
        prod_d  = 64'(mag_q[axis_q]) * 64'(scale_q[axis_q]);
        state_d = S_CHK;
      end
      S_CHK: begin
        ok_d = ok_all;
        if (axis_q == 2'(NUM_AXES - 1)) begin
          if (ok_all) begin
            state_d = S_READ;
          end else begin
            done_d  = 1'b1;
            bin_d   = (op_q == OP_LOOKUP) ? 32'd1 : 32'd0;
            inr_d   = 1'b0;
            state_d = S_IDLE;
          end
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        if (op_q == OP_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = cnt_new;
          cnt_wide  = 64'(cnt_new);
        end else begin
          cnt_wide  = 64'(ram_rdata);
        end
        bin_d   = (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : cnt_wide[31:0];
        inr_d   = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      axis_q    <= '0;
      op_q      <= '0;
      ok_q      <= 1'b0;
      total_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      axis_q    <= axis_d;
      op_q      <= op_d;
      ok_q      <= ok_d;
      total_q   <= total_d;
      done_q    <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    bin_q  <= bin_d;
    inr_q  <= inr_d;
    if (accept) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg_q[i] <= diff[i][32];
        mag_q[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
      end
    end
    if (state_q == S_CHK) begin
      // a negative axis in range has quotient zero, so index zero
      idx_q[axis_q] <= quot[AXIS_W-1:0];
    end
  end

  vh3_ram #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_WIDTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign bin_value_o     = bin_q;
  assign in_range_o      = inr_q;
  assign total_samples_o = total_q;

  // ---------------------------------------------------------------- checks
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_WB || $past(state_q) == S_CHK
                || $past(state_q) == S_IDLE))
    else $error("result strobe without a finishing step");

  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_WB))
    else $error("bin write outside sweep or write-back");

  a_inrange_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_range_o && done_o |-> $past(state_q) == S_WB)
    else $error("in-range result not from memory");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("request dropped");

  a_read_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> state_q == S_WB)
    else $error("read not followed by write-back");

endmodule

/* hw/rtl/vh3_ram.sv */
// Single-port synchronous RAM with registered read data.
module vh3_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
